// ===== rtl/rqir_pkg.sv =====
// shared types and constants for the indexed-remove ring queue
`default_nettype none

package rqir_pkg;

	localparam int DEPTH_DEFAULT     = 16;
	localparam int HANDLE_BITS       = 32;
	localparam int RING_LENGTH_BITS  = 5;
	localparam int RING_LENGTH_RESET = 16;
	localparam int POSITION_BITS     = 4;
	localparam int OCCUPANCY_BITS    = 5;

	typedef logic [HANDLE_BITS-1:0] handle_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PEEK   = 2'd2,
		OP_RMPOS  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_POS   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SH_RD,
		S_SH_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t                      operation;
		handle_t                  item_handle;
		logic [POSITION_BITS-1:0] position;
	} req_item_t;

	typedef struct packed {
		status_t                   status;
		handle_t                   result_handle;
		logic [OCCUPANCY_BITS-1:0] occupancy;
	} rsp_item_t;

endpackage

`default_nettype wire

// ===== rtl/ring_queue_indexed_remove.sv =====
// circular queue of job handles with insert, remove, peek and remove at position
`default_nettype none

// Ring queue of handles held in a single-port-write, registered-read memory of DEPTH
// slots; cfg_data sets the ring length (0 acts as 1, above DEPTH acts as DEPTH) and
// empties the queue. One request is worked on at a time and req_stall is high while
// it is in progress; the next request is taken while its result still waits on rsp.
// Insert and any failed request go from S_EXEC straight to S_DONE; remove and peek pass
// through S_READ; remove at position passes through S_READ, an S_SH_RD and S_SH_WR pair
// per entry behind the removed one and a last S_SH_RD, since each shifted entry is one
// memory read followed by one memory write through the same sequencer and wrap adder.
module ring_queue_indexed_remove
#(
	parameter int DEPTH = rqir_pkg::DEPTH_DEFAULT
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     req_valid,
	output logic                                    req_stall,
	input  wire  rqir_pkg::req_item_t               req,
	output logic                                    rsp_valid,
	input  wire                                     rsp_stall,
	output rqir_pkg::rsp_item_t                     rsp,
	input  wire                                     cfg_we,
	input  wire  [rqir_pkg::RING_LENGTH_BITS-1:0]   cfg_data
);

	import rqir_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SW    = ((CNT_W > POSITION_BITS) ? CNT_W : POSITION_BITS) + 1;
	localparam logic [CNT_W-1:0] LEN_RST =
		CNT_W'((RING_LENGTH_RESET > DEPTH) ? DEPTH : RING_LENGTH_RESET);

	state_t state_q, state_d;

	logic [CNT_W-1:0] len_q, count_q, idx_q;
	logic [PTR_W-1:0] head_q, tail_q, cur_q, nxt_q;
	op_t              op_q;
	handle_t          handle_q, res_q, rd_data_q;
	logic [POSITION_BITS-1:0] pos_q;
	status_t          status_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	handle_t          mem [DEPTH];
	logic             we;
	logic [PTR_W-1:0] waddr, raddr;
	handle_t          wdata;

	logic [PTR_W-1:0] wrap_a, wrap_y;
	logic [SW-1:0]    wrap_b, wrap_sum;
	logic [CNT_W-1:0] len_d;
	logic [31:0]      cfg_wide;

	logic full, empty, pos_bad, more, req_xfer, rsp_xfer, done_go;

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_xfer  = rsp_valid_q && !rsp_stall;
	assign done_go   = !rsp_valid_q || !rsp_stall;

	assign full    = (count_q >= len_q);
	assign empty   = (count_q == '0);
	assign pos_bad = (SW'(pos_q) >= SW'(count_q));
	assign more    = ((SW'(idx_q) + SW'(1)) < SW'(count_q));

	// effective ring length, clamped into 1..DEPTH
	always_comb begin
		cfg_wide = 32'(cfg_data);
		if (cfg_wide == 32'd0) begin
			len_d = CNT_W'(1);
		end else if (cfg_wide > 32'(DEPTH)) begin
			len_d = CNT_W'(DEPTH);
		end else begin
			len_d = CNT_W'(cfg_wide);
		end
	end

	// shared wrap adder: operands at most the ring length, one compare and subtract
	always_comb begin
		wrap_a = head_q;
		wrap_b = SW'(1);
		case (state_q)
			S_EXEC: begin
				case (op_q)
					OP_INSERT: wrap_a = tail_q;
					OP_REMOVE: wrap_a = head_q;
					default:   wrap_b = SW'(pos_q);
				endcase
			end
			S_SH_RD: wrap_a = cur_q;
			default: ;
		endcase
		wrap_sum = SW'(wrap_a) + wrap_b;
		if (wrap_sum >= SW'(len_q)) begin
			wrap_y = PTR_W'(wrap_sum - SW'(len_q));
		end else begin
			wrap_y = PTR_W'(wrap_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = cur_q;
		wdata   = rd_data_q;
		raddr   = cur_q;
		case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				case (op_q)
					OP_INSERT: begin
						if (!full) begin
							we    = 1'b1;
							waddr = tail_q;
							wdata = handle_q;
						end
					end
					OP_REMOVE: begin
						if (!empty) begin
							raddr   = head_q;
							state_d = S_READ;
						end
					end
					default: begin
						if (!pos_bad) begin
							raddr   = wrap_y;
							state_d = S_READ;
						end
					end
				endcase
			end
			S_READ: begin
				state_d = (op_q == OP_RMPOS) ? S_SH_RD : S_DONE;
			end
			S_SH_RD: begin
				raddr   = wrap_y;
				state_d = more ? S_SH_WR : S_DONE;
			end
			S_SH_WR: begin
				we      = 1'b1;
				waddr   = cur_q;
				wdata   = rd_data_q;
				state_d = S_SH_RD;
			end
			S_DONE: begin
				if (done_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_RST;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && done_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_xfer) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_EXEC: begin
					case (op_q)
						OP_INSERT: begin
							if (!full) begin
								tail_q  <= wrap_y;
								count_q <= count_q + CNT_W'(1);
							end
						end
						OP_REMOVE: begin
							if (!empty) begin
								head_q  <= wrap_y;
								count_q <= count_q - CNT_W'(1);
							end
						end
						default: ;
					endcase
				end
				S_SH_RD: begin
					if (!more) begin
						tail_q  <= (tail_q == '0) ? PTR_W'(len_q - CNT_W'(1))
						                          : tail_q - PTR_W'(1);
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: ;
			endcase
			// a ring length write empties the queue
			if (cfg_we) begin
				len_q   <= len_d;
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					op_q     <= req.operation;
					handle_q <= req.item_handle;
					pos_q    <= req.position;
				end
			end
			S_EXEC: begin
				res_q <= '0;
				case (op_q)
					OP_INSERT: status_q <= full ? ST_FULL : ST_OK;
					OP_REMOVE: status_q <= empty ? ST_EMPTY : ST_OK;
					default: begin
						if (pos_bad) begin
							status_q <= ST_POS;
						end else begin
							status_q <= ST_OK;
							cur_q    <= wrap_y;
							idx_q    <= CNT_W'(pos_q);
						end
					end
				endcase
			end
			S_READ: res_q <= rd_data_q;
			S_SH_RD: nxt_q <= wrap_y;
			S_SH_WR: begin
				cur_q <= nxt_q;
				idx_q <= idx_q + CNT_W'(1);
			end
			S_DONE: begin
				if (done_go) begin
					rsp_q.status        <= status_q;
					rsp_q.result_handle <= res_q;
					rsp_q.occupancy     <= OCCUPANCY_BITS'(count_q);
				end
			end
			default: ;
		endcase
	end

	a_count_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= len_q)
		else $error("occupancy above ring length");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> head_q == tail_q)
		else $error("empty queue with head and tail apart");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");

	a_fail_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != ST_OK |-> rsp_q.result_handle == '0)
		else $error("failed request carries a handle");

endmodule

`default_nettype wire

// ===== tb/tb_ring_queue_indexed_remove.sv =====
// self-checking testbench for the indexed-remove ring queue
module tb_ring_queue_indexed_remove;
	import rqir_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH           = DEPTH_DEFAULT;
	localparam int ITEMS_PER_PHASE = 94;
	localparam int PHASES          = 8;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_PHASE     = 4;
	localparam int SETTLE_CYCLES   = 2 * DEPTH + 8;
	localparam int MAX_REPORTS     = 60;
	localparam int WATCHDOG_NS     = 5_000_000;

	// ring length per phase, -1 picks one at random
	localparam int PHASE_RING_LENGTH[PHASES] = '{16, 31, 5, 1, 0, -1, 16, -1};
	localparam int PHASE_SEND_IDLE[PHASES]   = '{0, 83, 0, 37, 0, 83, 37, 0};
	localparam int PHASE_RECV_STALL[PHASES]  = '{0, 0, 83, 37, 0, 0, 37, 83};

	typedef struct {
		bit         is_cfg;
		logic [4:0] cfg_value;
		req_item_t  rq;
		bit         typed;
		rsp_item_t  typed_result;
	} stim_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        req_valid;
	logic                        req_stall;
	req_item_t                   req;
	logic                        rsp_valid;
	logic                        rsp_stall;
	rsp_item_t                   rsp;
	logic                        cfg_we;
	logic [RING_LENGTH_BITS-1:0] cfg_data;

	// predicted queue state
	handle_t    q_slots[DEPTH];
	logic [3:0] q_head;
	logic [3:0] q_tail;
	logic [4:0] q_count;
	logic [4:0] q_len;

	rsp_item_t pending_results[$];
	stim_row_t directed_rows[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asked     = 0;
	int mismatch_count = 0;
	int requests_sent  = 0;
	int results_checked = 0;
	int ring_settings  = 0;
	int status_seen[4] = '{0, 0, 0, 0};

	ring_queue_indexed_remove dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [3:0] ring_next(input int base, input int step);
		int s;
		s = base + step;
		if (s >= int'(q_len)) s -= int'(q_len);
		if (s >= DEPTH) s = 0;
		return 4'(s);
	endfunction

	function automatic void apply_ring_length(input logic [4:0] value);
		if (value == 5'd0) q_len = 5'd1;
		else if (int'(value) > DEPTH) q_len = 5'(DEPTH);
		else q_len = value;
		q_head  = '0;
		q_tail  = '0;
		q_count = '0;
	endfunction

	function automatic rsp_item_t compute_queue_result(input req_item_t rq);
		rsp_item_t  rs;
		logic [3:0] at;
		logic [3:0] dst;
		rs.status        = ST_OK;
		rs.result_handle = '0;
		case (rq.operation)
			OP_INSERT: begin
				if (q_count >= q_len) begin
					rs.status = ST_FULL;
				end else begin
					q_slots[q_tail] = rq.item_handle;
					q_tail  = ring_next(int'(q_tail), 1);
					q_count = q_count + 5'd1;
				end
			end
			OP_REMOVE: begin
				if (q_count == 5'd0) begin
					rs.status = ST_EMPTY;
				end else begin
					rs.result_handle = q_slots[q_head];
					q_head  = ring_next(int'(q_head), 1);
					q_count = q_count - 5'd1;
				end
			end
			default: begin
				// an empty queue fails here too, every position is out of range
				if ({1'b0, rq.position} >= q_count) begin
					rs.status = ST_POS;
				end else begin
					at = ring_next(int'(q_head), int'(rq.position));
					rs.result_handle = q_slots[at];
					if (rq.operation == OP_RMPOS) begin
						for (int i = int'(rq.position); i + 1 < int'(q_count); i++) begin
							dst = ring_next(int'(q_head), i);
							q_slots[dst] = q_slots[ring_next(int'(dst), 1)];
						end
						q_tail  = (q_tail == 4'd0) ? 4'(q_len - 5'd1) : q_tail - 4'd1;
						q_count = q_count - 5'd1;
					end
				end
			end
		endcase
		rs.occupancy = q_count;
		return rs;
	endfunction

	function automatic stim_row_t req_row(input op_t op, input handle_t h, input logic [3:0] p,
			input bit typed = 1'b0, input status_t st = ST_OK, input handle_t rh = '0,
			input logic [4:0] occ = '0);
		stim_row_t row;
		row.is_cfg                     = 1'b0;
		row.cfg_value                  = '0;
		row.rq.operation               = op;
		row.rq.item_handle             = h;
		row.rq.position                = p;
		row.typed                      = typed;
		row.typed_result.status        = st;
		row.typed_result.result_handle = rh;
		row.typed_result.occupancy     = occ;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [4:0] value);
		stim_row_t row;
		row           = req_row(OP_INSERT, '0, '0);
		row.is_cfg    = 1'b1;
		row.cfg_value = value;
		return row;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task automatic check_result(input rsp_item_t got);
		rsp_item_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing pending: status %0d handle %h occ %0d",
				got.status, got.result_handle, got.occupancy));
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		if (got.status !== want.status)
			report_mismatch($sformatf("result %0d status %0d, want %0d",
				results_checked, got.status, want.status));
		if (got.result_handle !== want.result_handle)
			report_mismatch($sformatf("result %0d handle %h, want %h",
				results_checked, got.result_handle, want.result_handle));
		if (got.occupancy !== want.occupancy)
			report_mismatch($sformatf("result %0d occupancy %0d, want %0d",
				results_checked, got.occupancy, want.occupancy));
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_request(input req_item_t rq, input bit use_typed,
			input rsp_item_t typed_result);
		rsp_item_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid            = 1'b0;
			req.operation        = op_t'($urandom_range(0, 3));
			req.item_handle      = $urandom;
			req.position         = 4'($urandom_range(0, 15));
			@(negedge clk);
		end
		req_valid = 1'b1;
		req       = rq;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predicted = compute_queue_result(rq);
		pending_results.push_back(use_typed ? typed_result : predicted);
		status_seen[int'(predicted.status)]++;
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		req_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_ring_length(input logic [4:0] value);
		wait_for_drain();
		cfg_we   = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		apply_ring_length(value);
		ring_settings++;
	endtask

	initial begin : response_side
		int hold_left;
		int hold_served;
		hold_left   = 0;
		hold_served = 0;
		rsp_stall   = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) check_result(rsp);
			@(negedge clk);
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_stall = 1'b1;
				hold_left--;
			end else begin
				rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	initial begin : stimulus
		req_item_t rq;
		int        r;
		int        len_sel;
		bit        filling;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_data  = '0;
		filling   = 1'b1;
		foreach (q_slots[i]) q_slots[i] = '0;
		apply_ring_length(5'(RING_LENGTH_RESET));

		// ring length 16 after reset
		directed_rows.push_back(req_row(OP_PEEK,   32'h0000_0000, 4'd0,  1'b1, ST_POS, '0, 5'd0));
		directed_rows.push_back(req_row(OP_RMPOS,  32'h0000_0000, 4'd15, 1'b1, ST_POS, '0, 5'd0));
		directed_rows.push_back(req_row(OP_REMOVE, 32'hFFFF_FFFF, 4'd0,  1'b1, ST_EMPTY, '0, 5'd0));
		directed_rows.push_back(req_row(OP_INSERT, 32'hFFFF_FFFF, 4'd15, 1'b1, ST_OK, '0, 5'd1));
		directed_rows.push_back(req_row(OP_INSERT, 32'h0000_0000, 4'd0,  1'b1, ST_OK, '0, 5'd2));
		directed_rows.push_back(req_row(OP_INSERT, 32'hA5A5_A5A5, 4'd7));
		directed_rows.push_back(req_row(OP_INSERT, 32'h5A5A_5A5A, 4'd8));
		directed_rows.push_back(req_row(OP_PEEK,   32'h1234_5678, 4'd0,  1'b1, ST_OK,
			32'hFFFF_FFFF, 5'd4));
		// position equal to occupancy
		directed_rows.push_back(req_row(OP_PEEK,   32'h0000_0000, 4'd4,  1'b1, ST_POS, '0, 5'd4));
		directed_rows.push_back(req_row(OP_RMPOS,  32'h0000_0000, 4'd1));
		directed_rows.push_back(req_row(OP_RMPOS,  32'h0000_0000, 4'd2));
		directed_rows.push_back(req_row(OP_REMOVE, 32'h0000_0000, 4'd0));
		directed_rows.push_back(req_row(OP_REMOVE, 32'h0000_0000, 4'd0));
		directed_rows.push_back(cfg_row(5'd1));
		directed_rows.push_back(req_row(OP_INSERT, 32'h1234_5678, 4'd0,  1'b1, ST_OK, '0, 5'd1));
		directed_rows.push_back(req_row(OP_INSERT, 32'hDEAD_BEEF, 4'd0,  1'b1, ST_FULL, '0, 5'd1));
		directed_rows.push_back(req_row(OP_RMPOS,  32'h0000_0000, 4'd0));
		directed_rows.push_back(req_row(OP_PEEK,   32'h0000_0000, 4'd15, 1'b1, ST_POS, '0, 5'd0));
		// zero acts as a ring of one
		directed_rows.push_back(cfg_row(5'd0));
		directed_rows.push_back(req_row(OP_INSERT, 32'h0F0F_0F0F, 4'd0,  1'b1, ST_OK, '0, 5'd1));
		directed_rows.push_back(req_row(OP_INSERT, 32'hF0F0_F0F0, 4'd0,  1'b1, ST_FULL, '0, 5'd1));
		// short ring so the tail and the shift wrap
		directed_rows.push_back(cfg_row(5'd3));
		directed_rows.push_back(req_row(OP_INSERT, 32'h1111_1111, 4'd0));
		directed_rows.push_back(req_row(OP_INSERT, 32'h2222_2222, 4'd0));
		directed_rows.push_back(req_row(OP_INSERT, 32'h3333_3333, 4'd0));
		directed_rows.push_back(req_row(OP_REMOVE, 32'h0000_0000, 4'd0));
		directed_rows.push_back(req_row(OP_INSERT, 32'h4444_4444, 4'd0));
		directed_rows.push_back(req_row(OP_RMPOS,  32'h0000_0000, 4'd0));

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_ring_length(directed_rows[i].cfg_value);
			else
				send_request(directed_rows[i].rq, directed_rows[i].typed,
					directed_rows[i].typed_result);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			len_sel = PHASE_RING_LENGTH[ph];
			if (len_sel < 0) len_sel = $urandom_range(1, DEPTH);
			write_ring_length(5'(len_sel));
			send_idle_pct  = PHASE_SEND_IDLE[ph];
			recv_stall_pct = PHASE_RECV_STALL[ph];
			// long receiver hold-off while requests keep coming
			if (ph == 0) hold_asked++;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == DRAIN_PHASE && n == ITEMS_PER_PHASE / 2) wait_for_drain();
				if (q_count >= q_len) filling = 1'b0;
				else if (q_count == 5'd0) filling = 1'b1;
				else if ($urandom_range(0, 99) < 4) filling = ~filling;
				r = $urandom_range(0, 99);
				if (filling)
					rq.operation = (r < 55) ? OP_INSERT : (r < 70) ? OP_PEEK :
						(r < 85) ? OP_REMOVE : OP_RMPOS;
				else
					rq.operation = (r < 15) ? OP_INSERT : (r < 45) ? OP_REMOVE :
						(r < 70) ? OP_PEEK : OP_RMPOS;
				r = $urandom_range(0, 99);
				rq.item_handle = (r < 10) ? '1 : (r < 20) ? '0 : handle_t'($urandom);
				if ($urandom_range(0, 99) < 80 && q_count != 5'd0)
					rq.position = 4'($urandom_range(0, int'(q_count) - 1));
				else
					rq.position = 4'($urandom_range(0, 15));
				send_request(rq, 1'b0, '0);
			end
		end

		wait_for_drain();
		// let a stray result from the longest shift show up
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d requests over %0d ring-length settings, %0d results compared",
			requests_sent, ring_settings, results_checked);
		$display("statuses predicted: ok %0d, full %0d, empty %0d, bad position %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("watchdog expired with %0d results still pending", pending_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rqir_pkg.sv
rtl/ring_queue_indexed_remove.sv
tb/tb_ring_queue_indexed_remove.sv
